// ===== rtl/hwc_pkg.sv =====
// Shared types and constants for the hardware cursor overlay.
package hwc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 14;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CURSOR_ON    = 3'd0,
        CFG_ARGB_FORMAT  = 3'd1,
        CFG_CURSOR_X     = 3'd2,
        CFG_CURSOR_Y     = 3'd3,
        CFG_COL_SKIP     = 3'd4,
        CFG_ROW_SKIP     = 3'd5,
        CFG_SCREEN_WIDTH = 3'd6
    } cfg_index_t;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    localparam logic [13:0] SCREEN_WIDTH_RST = 14'd640;

    typedef struct packed {
        logic        mode;
        logic [11:0] word_index;
        logic [15:0] word_data;
        logic [12:0] pixel_x;
        logic [11:0] pixel_y;
        logic [23:0] under_pixel;
    } in_item_t;

    typedef struct packed {
        logic [23:0] pixel_out;
        logic        cursor_hit;
    } out_item_t;

    typedef struct packed {
        logic        cursor_on;
        logic        argb_format;
        logic [12:0] cursor_x;
        logic [11:0] cursor_y;
        logic [5:0]  col_skip;
        logic [5:0]  row_skip;
        logic [13:0] screen_width;
    } cfg_t;

    // Pixel transaction waiting in the stage behind the bitmap read.
    typedef struct packed {
        logic        valid;
        logic        hit;
        logic        argb;
        logic [23:0] under;
    } s1_t;

endpackage

// ===== rtl/hwc_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module hwc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/hwc_addr.sv =====
// Cursor window test and bitmap address generation for one screen pixel.
module hwc_addr import hwc_pkg::*; #(
    parameter int CURSOR_SIDE = 64
) (
    input  cfg_t                                        cfg,
    input  logic [12:0]                                 pixel_x,
    input  logic [11:0]                                 pixel_y,
    output logic                                        hit,
    output logic [$clog2(CURSOR_SIDE*CURSOR_SIDE)-1:0]  addr
);

    localparam int IDX_W  = $clog2(CURSOR_SIDE);
    localparam int ADDR_W = $clog2(CURSOR_SIDE * CURSOR_SIDE);
    localparam logic [13:0] SIDE = 14'(CURSOR_SIDE);

    logic [13:0]      cx;
    logic [13:0]      dx;
    logic [13:0]      dy;
    logic [13:0]      rskip;
    logic [13:0]      cskip;
    logic [13:0]      rows;
    logic [13:0]      cols_side;
    logic [13:0]      room;
    logic [13:0]      cols;
    logic             win_ok;
    logic             y_in;
    logic             x_in;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] c_idx;

    always_comb
    begin
        cx        = {1'b0, cfg.cursor_x};
        dx        = {1'b0, pixel_x} - cx;
        dy        = {2'b00, pixel_y} - {2'b00, cfg.cursor_y};
        rskip     = {8'd0, cfg.row_skip};
        cskip     = {8'd0, cfg.col_skip};
        rows      = SIDE - rskip;
        cols_side = SIDE - cskip;
        room      = cfg.screen_width - cx;
        // The right screen edge may clip the visible columns further.
        cols      = (cols_side > room) ? room : cols_side;
        win_ok    = cfg.cursor_on && (rskip < SIDE) && (cskip < SIDE)
                    && (cx < cfg.screen_width);
        y_in      = (pixel_y >= cfg.cursor_y) && (dy < rows);
        x_in      = (pixel_x >= cfg.cursor_x) && (dx < cols);
        hit       = win_ok && y_in && x_in;
        r_idx     = IDX_W'(rskip + dy);
        c_idx     = IDX_W'(cskip + dx);
        addr      = ADDR_W'(r_idx) * ADDR_W'(CURSOR_SIDE) + ADDR_W'(c_idx);
    end

endmodule

// ===== rtl/hwc_blend.sv =====
// Mono AND/XOR and ARGB4444 compositing stages with the output register.
module hwc_blend import hwc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  s1_t         s1,
    input  logic [15:0] word,
    output logic        s1_take,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item
);

    localparam logic [3:0]  ALPHA_MAX = 4'd15;
    localparam logic [24:0] RECIP15   = 25'd4369;
    localparam int          AND_BIT   = 15;
    localparam int          XOR_BIT   = 14;

    // Exact floor(x / 15) for x below 3840: (x + 1) * 4369 >> 16.
    function automatic logic [7:0] div15(input logic [11:0] x);
        logic [24:0] p;
        p = 25'(x + 12'd1) * RECIP15;
        return p[23:16];
    endfunction

    logic [3:0]  alpha;
    logic [3:0]  alpha_n;
    logic [11:0] sum1 [3];
    logic [23:0] color;
    logic [23:0] res1;
    logic        blend1;

    logic        s2_valid_reg;
    logic        s2_valid_next;
    logic        s2_hit_reg;
    logic        s2_blend_reg;
    logic [23:0] s2_res_reg;
    logic [11:0] s2_sum_reg [3];

    logic        out_valid_reg;
    logic        out_valid_next;
    out_item_t   out_item_reg;
    logic [23:0] blended;
    logic        en_out;
    logic        en2;

    always_comb
    begin
        alpha   = word[15:12];
        alpha_n = ALPHA_MAX - alpha;
        color   = {word[11:8], word[11:8], word[7:4], word[7:4], word[3:0], word[3:0]};
        for (int i = 0; i < 3; i++)
        begin
            sum1[i] = 12'(s1.under[8*i +: 8]) * 12'(alpha_n)
                      + 12'(color[8*i +: 8]) * 12'(alpha);
        end
        blend1 = s1.hit && s1.argb && (alpha != 4'd0);
        res1   = s1.under;
        if (s1.hit && !s1.argb)
        begin
            if (!word[AND_BIT])
            begin
                res1 = color;
            end
            else if (word[XOR_BIT])
            begin
                res1 = ~s1.under;
            end
        end
    end

    assign en_out  = !out_valid_reg || out_ready;
    assign en2     = !s2_valid_reg || en_out;
    assign s1_take = en2;

    always_comb
    begin
        s2_valid_next  = en2 ? s1.valid : s2_valid_reg;
        out_valid_next = en_out ? s2_valid_reg : out_valid_reg;
        for (int i = 0; i < 3; i++)
        begin
            blended[8*i +: 8] = div15(s2_sum_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && s1.valid)
        begin
            s2_hit_reg   <= s1.hit;
            s2_blend_reg <= blend1;
            s2_res_reg   <= res1;
            s2_sum_reg   <= sum1;
        end
        if (en_out && s2_valid_reg)
        begin
            out_item_reg <= '{pixel_out:  s2_blend_reg ? blended : s2_res_reg,
                              cursor_hit: s2_hit_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== rtl/hw_cursor_overlay.sv =====
// Top level of the hardware cursor overlay: registers, bitmap store and pipeline.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_ready    in_item  (load word or screen pixel)
//   out      output     out_valid/out_ready  out_item (composited pixel, hit flag)
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// One transaction per cycle is taken while in_ready is high; a pixel's result reaches
// the output register through the bitmap read at the accepting edge, the blend
// products, then the divide and select.
// Loads write the bitmap store at acceptance and give no result.
// The bitmap store needs no clearing pass after reset.
// in_ready falls only when the output is stalled and every stage holds a pixel.
module hw_cursor_overlay import hwc_pkg::*; #(
    parameter int CURSOR_SIDE = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_item
);

    localparam int STORE_DEPTH = CURSOR_SIDE * CURSOR_SIDE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    cfg_t              cfg_reg;
    s1_t               s1_reg;
    s1_t               s1_next;
    logic              s1_take;
    logic              in_accept;
    logic              pixel_accept;
    logic              load_we;
    logic              pix_hit;
    logic [ADDR_W-1:0] pix_addr;
    logic [15:0]       word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{cursor_on:    1'b0,
                         argb_format:  1'b0,
                         cursor_x:     '0,
                         cursor_y:     '0,
                         col_skip:     '0,
                         row_skip:     '0,
                         screen_width: SCREEN_WIDTH_RST};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CURSOR_ON:    cfg_reg.cursor_on    <= cfg_data[0];
                CFG_ARGB_FORMAT:  cfg_reg.argb_format  <= cfg_data[0];
                CFG_CURSOR_X:     cfg_reg.cursor_x     <= cfg_data[12:0];
                CFG_CURSOR_Y:     cfg_reg.cursor_y     <= cfg_data[11:0];
                CFG_COL_SKIP:     cfg_reg.col_skip     <= cfg_data[5:0];
                CFG_ROW_SKIP:     cfg_reg.row_skip     <= cfg_data[5:0];
                CFG_SCREEN_WIDTH: cfg_reg.screen_width <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign in_ready     = !s1_reg.valid || s1_take;
    assign in_accept    = in_valid && in_ready;
    assign pixel_accept = in_accept && (in_item.mode == MODE_PIXEL);
    // Indexes past the end of the store are dropped.
    assign load_we      = in_accept && (in_item.mode == MODE_LOAD)
                          && (32'(in_item.word_index) < 32'(STORE_DEPTH));

    hwc_addr #(
        .CURSOR_SIDE (CURSOR_SIDE)
    ) u_addr (
        .cfg     (cfg_reg),
        .pixel_x (in_item.pixel_x),
        .pixel_y (in_item.pixel_y),
        .hit     (pix_hit),
        .addr    (pix_addr)
    );

    // Only one transaction enters per cycle, so a write and a read never collide,
    // and a load always lands before any later pixel reads the store.
    hwc_ram #(
        .WIDTH (16),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (load_we),
        .waddr (ADDR_W'(in_item.word_index)),
        .wdata (in_item.word_data),
        .re    (pixel_accept),
        .raddr (pix_addr),
        .rdata (word)
    );

    always_comb
    begin
        s1_next       = s1_reg;
        s1_next.valid = in_ready ? pixel_accept : s1_reg.valid;
        if (pixel_accept)
        begin
            s1_next.hit   = pix_hit;
            s1_next.argb  = cfg_reg.argb_format;
            s1_next.under = in_item.under_pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
        end
    end

    hwc_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1        (s1_reg),
        .word      (word),
        .s1_take   (s1_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

// ===== rtl/hwc_checks.sv =====
// Port-level checks for the hardware cursor overlay and their bind.
module hwc_checks import hwc_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_item,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled output transaction changed");

    // With room at the output the pipeline drains, so input is never refused.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
    else $error("input refused while the output could move");

    // With the output never stalled, an accepted pixel passes the s1, s2 and output registers and shows out_valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_item.mode == MODE_PIXEL && out_ready)
        ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("pixel result missing after pipeline latency");

    // With no input accepted and a free output while the s1, s2 and output registers drain, the pipeline is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && in_ready) && out_ready ##1 !(in_valid && in_ready) && out_ready
        ##1 !(in_valid && in_ready) && out_ready |=> !out_valid)
    else $error("output transaction appeared from an empty pipeline");

endmodule

bind hw_cursor_overlay hwc_checks u_hwc_checks (.*);
